// File: rtl/pmrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pmrr_pkg;

  localparam int unsigned W = 31;
  localparam int unsigned MULT_W = 15;
  localparam int unsigned PROD_W = W + MULT_W;

  localparam logic [W-1:0] PM_MODULUS = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0] PM_MULTIPLIER = 15'd16807;
  localparam logic [W-1:0] PM_SEED_RESET = 31'd3123;

  // one quotient bit per step
  localparam int unsigned DIV_STEPS = W;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic upd_en;
  } lcg_ctrl_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/pmrr_lcg.sv
`timescale 1ns / 1ps
`default_nettype none
module pmrr_lcg
  import pmrr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lcg_ctrl_t ctrl,
  output logic [W-1:0]   seed,
  output logic [W-1:0]   seed_next
);

  logic [W-1:0]      seed_r;
  logic [PROD_W-1:0] prod_r;
  logic [W:0]        fold;
  logic [W:0]        fold_sub;

  // 2^31 == 1 mod (2^31 - 1): fold the high part onto the low part
  always_comb begin
    fold = {1'b0, prod_r[W-1:0]} + {{(W + 1 - MULT_W){1'b0}}, prod_r[PROD_W-1:W]};
    fold_sub = fold - {1'b0, PM_MODULUS};
    if (fold >= {1'b0, PM_MODULUS}) begin
      seed_next = fold_sub[W-1:0];
    end else begin
      seed_next = fold[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(seed_r) * PROD_W'(PM_MULTIPLIER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= PM_SEED_RESET;
    end else if (ctrl.upd_en) begin
      seed_r <= seed_next;
    end
  end

  assign seed = seed_r;

endmodule
`default_nettype wire

// File: rtl/pmrr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pmrr_div
  import pmrr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire div_ctrl_t    ctrl,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic [W-1:0]      rem,
  output logic              last
);

  logic [W-1:0]     dvd_r;
  logic [W:0]       rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  // restoring remainder, one bit per cycle
  always_comb begin
    shifted = {rem_r[W-1:0], dvd_r[W-1]};
    diff = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (ctrl.step) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        rem_r <= diff;
      end else begin
        rem_r <= shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.start) begin
      cnt_r <= '0;
    end else if (ctrl.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign rem = rem_r[W-1:0];

endmodule
`default_nettype wire

// File: rtl/park_miller_random_range.sv
// An accepted request passes through a multiply, a fold, 31 steps of the
// bit-serial remainder unit and an output load; a zero limit skips the steps.
// Requests are handled one at a time: a new one is taken once the result is in
// the output register, also while that result waits. The load waits for room.
// Reset (rst_n, synchronous, active low): seed returns to 3123, FSM idles,
// output register empties.
`timescale 1ns / 1ps
`default_nettype none
module park_miller_random_range
  import pmrr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_range_limit,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_value
);

  state_t       state_r, state_nxt;
  logic [W-1:0] limit_r;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_value_r;
  logic         load_out;

  lcg_ctrl_t    lcg_ctrl;
  div_ctrl_t    div_ctrl;
  logic [W-1:0] seed;
  logic [W-1:0] seed_next;
  logic [W-1:0] rem;
  logic         div_last;
  logic         limit_zero;

  assign limit_zero = (limit_r == '0);

  // generator: product register plus mod (2^31-1) fold
  pmrr_lcg u_lcg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lcg_ctrl),
    .seed      (seed),
    .seed_next (seed_next)
  );

  // remainder unit; loads the freshly folded seed
  pmrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (seed_next),
    .divisor  (limit_r),
    .rem      (rem),
    .last     (div_last)
  );

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    lcg_ctrl.mul_en = 1'b0;
    lcg_ctrl.upd_en = 1'b0;
    div_ctrl.start  = 1'b0;
    div_ctrl.step   = 1'b0;
    load_out        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        lcg_ctrl.mul_en = 1'b1;
        state_nxt       = ST_RED;
      end
      ST_RED: begin
        lcg_ctrl.upd_en = 1'b1;
        div_ctrl.start  = 1'b1;
        state_nxt       = limit_zero ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        if (div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      limit_r <= in_range_limit;
    end
    if (load_out) begin
      // rem < limit <= 2^31-1, so rem+1 fits
      out_value_r <= limit_zero ? seed : rem + 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule
`default_nettype wire

// File: verif/park_miller_random_range_test.sv
`timescale 1ns / 1ps
module park_miller_random_range_test;
  import pmrr_pkg::W;

  // Generator constants: modulus 2^31-1, multiplier 7^5, seed after reset
  localparam logic [63:0] LCG_MOD  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LCG_MULT = 64'd16807;
  localparam logic [W-1:0] LCG_SEED0 = 31'd3123;
  localparam logic [W-1:0] LIMIT_MAX = 31'h7FFF_FFFF;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int HOLD_LEN    = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES = 40;    // tail wait, longer than one request's trip through the block

  typedef struct {
    logic [W-1:0] limit;
    logic [W-1:0] value;
  } draw_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] in_range_limit = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] out_value;

  // Requests waiting to be offered, and draws still owed by the block
  logic [W-1:0] pending_limits[$];
  draw_t        draws_due[$];

  // Predictor state
  logic [W-1:0] gen_seed = LCG_SEED0;
  draw_t        due;

  // Handshake and idling control
  logic req_fire = 1'b0;  // request taken at the last rising edge
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   hold_ask = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  // Bookkeeping
  int idle_cycles = 0;
  int mismatch_cnt = 0;
  int reqs_sent = 0;
  int draws_checked = 0;
  int raw_draws = 0;
  int unit_draws = 0;

  park_miller_random_range dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_range_limit(in_range_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value)
  );

  always #5 clk = ~clk;

  // One generator step: exact product reduced mod 2^31-1
  function automatic logic [W-1:0] lcg_step(input logic [W-1:0] s);
    logic [63:0] prod;
    prod = {33'b0, s} * LCG_MULT;
    return W'(prod % LCG_MOD);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: feeds from pending_limits, changes inputs on falling edges.
  // Once valid is up it stays up, payload frozen, until the handshake.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (pending_limits.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid       <= 1'b1;
        in_range_limit <= pending_limits.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on demand. The
  // hold-off is counted here so the sender keeps offering meanwhile.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples on rising edges. Results are checked before the request
  // of the same edge is predicted; a request can never answer in its own cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (draws_due.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual value %0d",
                   $time, out_value);
        end else begin
          due = draws_due.pop_front();
          draws_checked++;
          if (out_value !== due.value) begin
            mismatch_cnt++;
            $display("%0t: value mismatch (limit %0d), expected %0d, actual %0d",
                     $time, due.limit, due.value, out_value);
          end
        end
      end

      if (in_valid && in_ready) begin
        // advance first, then reduce the new seed to the range
        gen_seed  = lcg_step(gen_seed);
        due.limit = in_range_limit;
        if (in_range_limit == '0) begin
          due.value = gen_seed;
          raw_draws++;
        end else begin
          due.value = (gen_seed % in_range_limit) + 1'b1;
          if (in_range_limit == 31'd1) unit_draws++;
        end
        draws_due.push_back(due);
        reqs_sent++;
      end

      // watchdog: count edges with no handshake on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no handshake for %0d cycles, %0d draws outstanding",
                   $time, STALL_LIMIT, draws_due.size());
          $display("** park_miller_random_range: FAILED **");
          $finish;
        end
      end
    end
  end

  // Wait until every queued request went in and every draw came back
  task automatic drain();
    while (pending_limits.size() != 0 || in_valid || draws_due.size() != 0)
      @(posedge clk);
  endtask

  // Random phase: small, random 31-bit and near-maximum ranges, with zero, one
  // and near-power-of-two limits mixed in.
  task automatic run_phase(input int n, input int snd, input int rcv, input bit squeeze);
    logic [W-1:0] lim;
    int           sh;
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    if (squeeze) hold_ask++;
    for (int i = 0; i < n; i++) begin
      sh = $urandom_range(30);
      case ($urandom_range(9))
        0:       lim = '0;
        1:       lim = 31'd1;
        2, 3, 4: lim = W'($urandom_range(100, 2));
        5, 6:    lim = W'($urandom()) & LIMIT_MAX;
        7:       lim = (31'd1 << sh) + W'($urandom_range(2)) - 31'd1;
        default: lim = LIMIT_MAX - W'($urandom_range(1000));
      endcase
      pending_limits.push_back(lim);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero limit (raw seed), limit of one, tiny and extreme ranges,
    // alternating bit patterns, and the generator's own constants.
    pending_limits = '{31'd0, 31'd1, 31'd2, 31'd3, LIMIT_MAX, 31'h4000_0000,
                       31'h7FFF_FFFE, 31'd0, 31'd1, 31'h5555_5555, 31'h2AAA_AAAA,
                       31'd6, 31'd10, 31'd100, 31'd16807, 31'd127773, 31'd2836,
                       31'd3123, 31'd0, 31'd1, LIMIT_MAX, 31'd0};
    drain();

    // no idling, with a long receiver hold-off so the block backs up
    run_phase(300, 0, 0, 1'b1);
    run_phase(300, 84, 0, 1'b0);
    run_phase(300, 0, 84, 1'b0);
    run_phase(300, 33, 33, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (draws_due.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: %0d draws never arrived, expected value %0d first, actual none",
               $time, draws_due.size(), draws_due[0].value);
    end

    $display("Covered %0d requests (%0d raw-seed, %0d unit-range), %0d draws checked,",
             reqs_sent, raw_draws, unit_draws, draws_checked);
    $display("across sender gaps, receiver stalls and a long back-pressure hold; %0d errors",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("** park_miller_random_range: PASSED **");
    end else begin
      $display("** park_miller_random_range: FAILED **");
    end
    $finish;
  end

endmodule
